[rtl/core/nec_enc_pkg.sv]
package nec_enc_pkg;

    localparam int DUR_W   = 16;   // duration and count width
    localparam int KHZ_W   = 10;   // carrier frequency register width
    localparam int IDX_W   = 3;    // configuration index width
    localparam int BYTE_W  = 8;
    localparam int FRAME_W = 4 * BYTE_W;
    localparam int PAIR_W  = 6;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_CARRIER_KHZ  = 3'd0;
    localparam logic [IDX_W-1:0] REG_HEADER_MARK  = 3'd1;
    localparam logic [IDX_W-1:0] REG_HEADER_SPACE = 3'd2;
    localparam logic [IDX_W-1:0] REG_BIT_MARK     = 3'd3;
    localparam logic [IDX_W-1:0] REG_ZERO_SPACE   = 3'd4;
    localparam logic [IDX_W-1:0] REG_ONE_SPACE    = 3'd5;
    localparam logic [IDX_W-1:0] REG_STOP_MARK    = 3'd6;

    // Reset values
    localparam logic [KHZ_W-1:0] RST_CARRIER_KHZ  = 10'd38;
    localparam logic [DUR_W-1:0] RST_HEADER_MARK  = 16'd9000;
    localparam logic [DUR_W-1:0] RST_HEADER_SPACE = 16'd4474;
    localparam logic [DUR_W-1:0] RST_BIT_MARK     = 16'd560;
    localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 16'd534;
    localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 16'd1664;
    localparam logic [DUR_W-1:0] RST_STOP_MARK    = 16'd560;

    // Carrier period is this over the frequency in kHz
    localparam logic [DUR_W-1:0] PERIOD_NUM = 16'd1000;

    // Pair positions within a frame
    localparam logic [PAIR_W-1:0] PAIR_HEADER    = 6'd0;
    localparam logic [PAIR_W-1:0] PAIR_LAST_DATA = 6'd32;
    localparam logic [PAIR_W-1:0] PAIR_STOP      = 6'd33;

    typedef struct packed {
        logic [BYTE_W-1:0] device_address;
        logic [BYTE_W-1:0] command_code;
    } nec_in_t;

    typedef struct packed {
        logic [DUR_W-1:0] mark_cycles;
        logic [DUR_W-1:0] space_cycles;
        logic             frame_end;
    } nec_out_t;

endpackage

[rtl/core/nec_ir_frame_encoder.sv]
// NEC infrared frame encoder.
// Input channel (in_valid / in_stall / in_data): one transfer carries an address
// byte and a command byte. The frame sent is address, ~address, command,
// ~command, each LSB first.
// Output channel (out_valid / out_stall / out_data): one transfer per mark/space
// pair, in carrier periods: header pair, 32 data pairs, then a stop pair with a
// zero space unless the stop mark is programmed to 0. frame_end flags the last.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
// ready; indexes beyond the stop mark register are dropped. Write only when idle.
// Timing: a single restoring divider (one quotient bit a cycle) first forms the
// carrier period, then the six pair durations. After that, pairs follow one per
// cycle while the output is not stalled.
// in_stall stays high from acceptance until the last pair is in the output
// register. An out-of-range carrier yields no pairs: a zero carrier returns the
// block to idle at the load step, one above 1000 kHz after the period division.
// Output stall holds the pair register; the sequencer simply waits.
// Reset: registers take their default NEC timings (38 kHz), output is empty.
module nec_ir_frame_encoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  nec_enc_pkg::nec_in_t                in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output nec_enc_pkg::nec_out_t               out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nec_enc_pkg::IDX_W-1:0]       cfg_index,
    input  logic [nec_enc_pkg::DUR_W-1:0]       cfg_data
);

    localparam int DUR_W  = nec_enc_pkg::DUR_W;
    localparam int KHZ_W  = nec_enc_pkg::KHZ_W;
    localparam int STEP_W = $clog2(DUR_W);
    localparam int N_DUR  = 6;
    localparam int SEL_W  = 3;

    // Division slots: 0 is the carrier period, the rest are durations
    localparam logic [SEL_W-1:0] SEL_PERIOD = 3'd0;
    localparam logic [SEL_W-1:0] SEL_HM     = 3'd1;
    localparam logic [SEL_W-1:0] SEL_HS     = 3'd2;
    localparam logic [SEL_W-1:0] SEL_BM     = 3'd3;
    localparam logic [SEL_W-1:0] SEL_ZS     = 3'd4;
    localparam logic [SEL_W-1:0] SEL_OS     = 3'd5;
    localparam logic [SEL_W-1:0] SEL_SM     = 3'd6;

    // Slots in the duration store
    localparam int D_HM = 0;
    localparam int D_HS = 1;
    localparam int D_BM = 2;
    localparam int D_ZS = 3;
    localparam int D_OS = 4;
    localparam int D_SM = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Configuration registers
    logic [KHZ_W-1:0] carrier_khz_reg;
    logic [DUR_W-1:0] header_mark_reg;
    logic [DUR_W-1:0] header_space_reg;
    logic [DUR_W-1:0] bit_mark_reg;
    logic [DUR_W-1:0] zero_space_reg;
    logic [DUR_W-1:0] one_space_reg;
    logic [DUR_W-1:0] stop_mark_reg;

    // Sequencer and datapath
    state_t                        state_reg;
    logic [SEL_W-1:0]              sel_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [KHZ_W-1:0]              divisor_reg;
    logic [KHZ_W-1:0]              rem_reg;
    logic [DUR_W-1:0]              quo_reg;
    logic [KHZ_W-1:0]              period_reg;
    logic [DUR_W-1:0]              dur_reg [N_DUR];
    logic [nec_enc_pkg::FRAME_W-1:0] bits_reg;
    logic [nec_enc_pkg::PAIR_W-1:0]  pair_reg;
    logic                          out_valid_reg;
    nec_enc_pkg::nec_out_t         out_data_reg;

    // Divider step and operand selection
    logic [KHZ_W:0]   rem_shift;
    logic             rem_ge;
    logic [KHZ_W-1:0] rem_diff;
    logic [KHZ_W-1:0] rem_next;
    logic [DUR_W-1:0] quo_next;
    logic [DUR_W-1:0] dividend_sel;
    logic [KHZ_W-1:0] divisor_sel;
    logic             has_stop;
    logic [nec_enc_pkg::PAIR_W-1:0] last_pair;
    logic             out_free;
    nec_enc_pkg::nec_out_t pair_next;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign has_stop  = (stop_mark_reg != '0);
    assign last_pair = has_stop ? nec_enc_pkg::PAIR_STOP : nec_enc_pkg::PAIR_LAST_DATA;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_khz_reg  <= nec_enc_pkg::RST_CARRIER_KHZ;
            header_mark_reg  <= nec_enc_pkg::RST_HEADER_MARK;
            header_space_reg <= nec_enc_pkg::RST_HEADER_SPACE;
            bit_mark_reg     <= nec_enc_pkg::RST_BIT_MARK;
            zero_space_reg   <= nec_enc_pkg::RST_ZERO_SPACE;
            one_space_reg    <= nec_enc_pkg::RST_ONE_SPACE;
            stop_mark_reg    <= nec_enc_pkg::RST_STOP_MARK;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                nec_enc_pkg::REG_CARRIER_KHZ:  carrier_khz_reg  <= cfg_data[KHZ_W-1:0];
                nec_enc_pkg::REG_HEADER_MARK:  header_mark_reg  <= cfg_data;
                nec_enc_pkg::REG_HEADER_SPACE: header_space_reg <= cfg_data;
                nec_enc_pkg::REG_BIT_MARK:     bit_mark_reg     <= cfg_data;
                nec_enc_pkg::REG_ZERO_SPACE:   zero_space_reg   <= cfg_data;
                nec_enc_pkg::REG_ONE_SPACE:    one_space_reg    <= cfg_data;
                nec_enc_pkg::REG_STOP_MARK:    stop_mark_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Operands for the current division slot
    always_comb
    begin
        divisor_sel = period_reg;
        case (sel_reg)
            SEL_PERIOD:
            begin
                dividend_sel = nec_enc_pkg::PERIOD_NUM;
                divisor_sel  = carrier_khz_reg;
            end
            SEL_HM:  dividend_sel = header_mark_reg;
            SEL_HS:  dividend_sel = header_space_reg;
            SEL_BM:  dividend_sel = bit_mark_reg;
            SEL_ZS:  dividend_sel = zero_space_reg;
            SEL_OS:  dividend_sel = one_space_reg;
            SEL_SM:  dividend_sel = stop_mark_reg;
            default: dividend_sel = '0;
        endcase
    end

    // One restoring step: remainder always stays below the divisor
    assign rem_shift = {rem_reg, quo_reg[DUR_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, divisor_reg});
    assign rem_diff  = rem_shift[KHZ_W-1:0] - divisor_reg;
    assign rem_next  = rem_ge ? rem_diff : rem_shift[KHZ_W-1:0];
    assign quo_next  = {quo_reg[DUR_W-2:0], rem_ge};

    // Pair for the current position
    always_comb
    begin
        pair_next.frame_end = (pair_reg == last_pair);
        if (pair_reg == nec_enc_pkg::PAIR_HEADER)
        begin
            pair_next.mark_cycles  = dur_reg[D_HM];
            pair_next.space_cycles = dur_reg[D_HS];
        end
        else if (pair_reg == nec_enc_pkg::PAIR_STOP)
        begin
            pair_next.mark_cycles  = dur_reg[D_SM];
            pair_next.space_cycles = '0;
        end
        else
        begin
            pair_next.mark_cycles  = dur_reg[D_BM];
            pair_next.space_cycles = bits_reg[0] ? dur_reg[D_OS] : dur_reg[D_ZS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= SEL_PERIOD;
            step_reg      <= '0;
            pair_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // while emitting, the emit arm owns the output register
            if (out_valid_reg && !out_stall && state_reg != ST_EMIT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        bits_reg  <= {~in_data.command_code, in_data.command_code,
                                      ~in_data.device_address, in_data.device_address};
                        sel_reg   <= SEL_PERIOD;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    quo_reg     <= dividend_sel;
                    divisor_reg <= divisor_sel;
                    rem_reg     <= '0;
                    step_reg    <= '0;
                    state_reg   <= (divisor_sel == '0) ? ST_IDLE : ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg  <= rem_next;
                    quo_reg  <= quo_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DUR_W - 1))
                    begin
                        if (sel_reg == SEL_PERIOD)
                        begin
                            period_reg <= quo_next[KHZ_W-1:0];
                            // khz above 1000 gives a zero period: no frame
                            state_reg  <= (quo_next == '0) ? ST_IDLE : ST_LOAD;
                        end
                        else
                        begin
                            dur_reg[sel_reg - 1'b1] <= quo_next;
                            state_reg <= (sel_reg == SEL_SM) ? ST_EMIT : ST_LOAD;
                        end
                        sel_reg  <= sel_reg + 1'b1;
                        pair_reg <= nec_enc_pkg::PAIR_HEADER;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= pair_next;
                        pair_reg      <= pair_reg + 1'b1;
                        if (pair_reg != nec_enc_pkg::PAIR_HEADER)
                            bits_reg <= bits_reg >> 1;
                        if (pair_reg == last_pair)
                            state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
